// ----- rtl/bras_pkg.sv -----
package bras_pkg;

  // Default geometry and fixed-point format.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 8;

  // Fixed field widths of the stream and configuration ports.
  localparam int COORD_W    = 17;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Operation codes carried in in_tuser.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Register indexes (word address on the configuration port).
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_ADDR,
    S_MEM,
    S_WGT,
    S_WLAT,
    S_MAC,
    S_DRAIN,
    S_OUT
  } st_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MS_ADDR,
    MS_WGT,
    MS_MAC
  } mul_sel_t;

  // Control strobes decoded from the sequencer state.
  typedef struct packed {
    logic     ready;
    logic     prep;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     mem_we;
    logic     mem_re;
    logic     wlat;
    logic     mac;
    logic     out_ld;
  } ctl_t;

endpackage

// ----- rtl/bilinear_rgba_sampler_top.sv -----
// Byte image store with a bilinear sampler. A write transaction stores one pixel at the floor
// of its fixed-point coordinate, a read returns one pixel, and a sample returns the bilinear
// blend of the four clamped neighbors, each channel rounded up and saturated to 0..255. Every
// accepted request other than operation code three gives exactly one result; out_of_range in
// out_tuser flags a read or write outside the configured image. The block handles one request
// at a time: the input stays closed until its result is loaded into the output
// register; an ignored code is taken while idle. A finished result waits in the output
// register while the next request is taken. The sample time is set by the single shared
// multiplier and the single port of the pixel memory: each of the four corners needs an
// address product, a memory read, a weight product and four channel products. The memory
// needs no clearing after reset; pixels must be written before they are read or sampled.
// Registers: 0x0 image width, 0x4 image height, 0x8 alpha enable; write them only while idle.
module bilinear_rgba_sampler_top
  import bras_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // coord_x[16:0], coord_y[33:17], red_in[41:34], green_in[49:42], blue_in[57:50],
  // alpha_in[65:58], zero fill [71:66]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [1:0]            in_tuser,
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_of_range[0]
  output logic [0:0]            out_tuser,
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CW     = COORD_W;
  localparam int EXT_W  = CW + 1;
  localparam int XI_W   = $clog2(MAX_WIDTH);
  localparam int YI_W   = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW_W = ((WW > 9) ? WW : 9) + 1;
  localparam int CMPH_W = ((HW > 9) ? HW : 9) + 1;
  localparam int POS_W  = ((XI_W > YI_W) ? XI_W : YI_W) + FRAC_BITS;
  localparam int DIFF_W = ((POS_W > 16) ? POS_W : 16) + 2;
  localparam int WGT_W  = 2 * DIFF_W;
  localparam int P_W    = 3 * DIFF_W;
  localparam int ACC_W  = WGT_W + 12;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'((64'd1 << (2 * FRAC_BITS)) - 64'd1);

  // Configuration registers.
  logic [8:0] width_r;
  logic [8:0] height_r;
  logic       alpha_en_r;
  logic       cfg_we;

  // Sequencer and datapath registers.
  st_t                      state_r, state_nxt;
  ctl_t                     ctl;
  logic [1:0]               op_r;
  logic [CW-1:0]            cx_r, cy_r;
  logic [31:0]              wr_word_r;
  logic                     oor_r;
  logic [XI_W-1:0]          xa_r, xb_r;
  logic [YI_W-1:0]          ya_r, yb_r;
  logic signed [DIFF_W-1:0] dxa_r, dxb_r, dya_r, dyb_r;
  logic [1:0]               k_r, ch_r;
  logic signed [WGT_W-1:0]  wgt_r;
  logic [31:0]              pix_r;
  logic [31:0]              rdata_r;
  logic signed [ACC_W-1:0]  acc_r [4];
  logic                     acc_en_r;
  logic [1:0]               acc_ch_r;
  logic                     out_tvalid_r;
  logic [OUT_DATA_W-1:0]    out_tdata_r;
  logic                     out_tuser_r;
  logic [31:0]              mem [DEPTH];

  // Combinational helpers.
  logic [WW-1:0]            eff_w;
  logic [HW-1:0]            eff_h;
  logic [CMPW_W-1:0]        width_ext;
  logic [CMPH_W-1:0]        height_ext;
  logic signed [CW-1:0]     fx, fy;
  logic signed [EXT_W-1:0]  fx_e, fy_e, fx1, fy1, lim_x, lim_y;
  logic signed [EXT_W-1:0]  xa_c, xb_c, ya_c, yb_c;
  logic signed [DIFF_W-1:0] cx_d, cy_d, pos_xa, pos_xb, pos_ya, pos_yb;
  logic                     oor_c;
  logic                     in_acc;
  logic [XI_W-1:0]          x_sel;
  logic [YI_W-1:0]          y_sel;
  logic signed [DIFF_W-1:0] dx_sel, dy_sel;
  logic [AW-1:0]            mem_addr;
  logic signed [P_W-1:0]    prod;
  logic [31:0]              res_word;
  logic [31:0]              smp_word;

  function automatic logic signed [EXT_W-1:0] clamp_e(input logic signed [EXT_W-1:0] v,
                                                      input logic signed [EXT_W-1:0] lim);
    logic signed [EXT_W-1:0] r;
    if (v[EXT_W-1]) begin
      r = '0;
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration writes and read-back.
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 9'd256;
      height_r   <= 9'd256;
      alpha_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_paddr[3:2])
        REG_WIDTH:  width_r    <= cfg_pwdata[8:0];
        REG_HEIGHT: height_r   <= cfg_pwdata[8:0];
        REG_ALPHA:  alpha_en_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_WIDTH:  cfg_prdata = {23'd0, width_r};
      REG_HEIGHT: cfg_prdata = {23'd0, height_r};
      REG_ALPHA:  cfg_prdata = {31'd0, alpha_en_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // Effective image size: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    width_ext  = CMPW_W'(width_r);
    height_ext = CMPH_W'(height_r);
    if (width_r == 9'd0) begin
      eff_w = WW'(1);
    end else if (width_ext > CMPW_W'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext[WW-1:0];
    end
    if (height_r == 9'd0) begin
      eff_h = HW'(1);
    end else if (height_ext > CMPH_W'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = height_ext[HW-1:0];
    end
  end

  // Floor of the coordinates, clamped corners, range flag and corner distances.
  always_comb begin
    fx     = $signed(cx_r) >>> FRAC_BITS;
    fy     = $signed(cy_r) >>> FRAC_BITS;
    fx_e   = $signed({fx[CW-1], fx});
    fy_e   = $signed({fy[CW-1], fy});
    fx1    = fx_e + $signed(EXT_W'(1));
    fy1    = fy_e + $signed(EXT_W'(1));
    lim_x  = $signed(EXT_W'(eff_w)) - $signed(EXT_W'(1));
    lim_y  = $signed(EXT_W'(eff_h)) - $signed(EXT_W'(1));
    xa_c   = clamp_e(fx_e, lim_x);
    xb_c   = clamp_e(fx1, lim_x);
    ya_c   = clamp_e(fy_e, lim_y);
    yb_c   = clamp_e(fy1, lim_y);
    oor_c  = fx_e[EXT_W-1] || (fx_e > lim_x) || fy_e[EXT_W-1] || (fy_e > lim_y);
    cx_d   = $signed({{(DIFF_W-CW){cx_r[CW-1]}}, cx_r});
    cy_d   = $signed({{(DIFF_W-CW){cy_r[CW-1]}}, cy_r});
    pos_xa = $signed({{(DIFF_W-XI_W-FRAC_BITS){1'b0}}, xa_c[XI_W-1:0], {FRAC_BITS{1'b0}}});
    pos_xb = $signed({{(DIFF_W-XI_W-FRAC_BITS){1'b0}}, xb_c[XI_W-1:0], {FRAC_BITS{1'b0}}});
    pos_ya = $signed({{(DIFF_W-YI_W-FRAC_BITS){1'b0}}, ya_c[YI_W-1:0], {FRAC_BITS{1'b0}}});
    pos_yb = $signed({{(DIFF_W-YI_W-FRAC_BITS){1'b0}}, yb_c[YI_W-1:0], {FRAC_BITS{1'b0}}});
  end

  // Corner selection: bit one of the corner count picks the column, bit zero the row.
  assign x_sel  = k_r[1] ? xb_r : xa_r;
  assign y_sel  = k_r[0] ? yb_r : ya_r;
  assign dx_sel = k_r[1] ? dxb_r : dxa_r;
  assign dy_sel = k_r[0] ? dyb_r : dya_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && (in_tuser != OP_NONE)) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if ((op_r != OP_SAMPLE) && oor_c) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: state_nxt = S_MEM;
      S_MEM: begin
        if (op_r == OP_SAMPLE) begin
          state_nxt = S_WGT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_WGT:  state_nxt = S_WLAT;
      S_WLAT: state_nxt = S_MAC;
      S_MAC: begin
        if (ch_r == 2'd3) begin
          state_nxt = (k_r == 2'd3) ? S_DRAIN : S_ADDR;
        end
      end
      S_DRAIN: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    ctl = '0;
    ctl.mul_sel = MS_ADDR;
    unique case (state_r)
      S_IDLE: ctl.ready = 1'b1;
      S_PREP: ctl.prep  = 1'b1;
      S_ADDR: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_ADDR;
      end
      S_MEM: begin
        ctl.mem_we = (op_r == OP_WRITE);
        ctl.mem_re = (op_r != OP_WRITE);
      end
      S_WGT: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_WGT;
      end
      S_WLAT: ctl.wlat = 1'b1;
      S_MAC: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_MAC;
        ctl.mac     = 1'b1;
      end
      S_DRAIN: ;
      S_OUT:   ctl.out_ld = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  assign in_tready = ctl.ready;
  assign in_acc    = in_tvalid && in_tready;

  // Sequencer state, counters and accumulate strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      acc_en_r <= 1'b0;
      k_r      <= 2'd0;
      ch_r     <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      acc_en_r <= ctl.mac;
      if (ctl.prep) begin
        k_r  <= 2'd0;
        ch_r <= 2'd0;
      end else if (ctl.mac) begin
        ch_r <= ch_r + 2'd1;
        if (ch_r == 2'd3) begin
          k_r <= k_r + 2'd1;
        end
      end
    end
  end

  // Request capture and per-request setup.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_tuser;
      cx_r      <= in_tdata[16:0];
      cy_r      <= in_tdata[33:17];
      wr_word_r <= {alpha_en_r ? in_tdata[65:58] : 8'd0, in_tdata[57:50], in_tdata[49:42],
                    in_tdata[41:34]};
    end
    if (ctl.prep) begin
      oor_r <= oor_c;
      xa_r  <= xa_c[XI_W-1:0];
      xb_r  <= xb_c[XI_W-1:0];
      ya_r  <= ya_c[YI_W-1:0];
      yb_r  <= yb_c[YI_W-1:0];
      dxa_r <= pos_xb - cx_d;
      dxb_r <= cx_d - pos_xa;
      dya_r <= pos_yb - cy_d;
      dyb_r <= cy_d - pos_ya;
    end
    if (ctl.wlat) begin
      wgt_r <= prod[WGT_W-1:0];
      pix_r <= rdata_r;
    end
    if (ctl.mac) begin
      acc_ch_r <= ch_r;
    end
  end

  // Shared multiplier.
  bras_mul #(
    .Y_W    (YI_W),
    .W_W    (WW),
    .DIFF_W (DIFF_W)
  ) u_mul (
    .clk      (clk),
    .en       (ctl.mul_en),
    .sel      (ctl.mul_sel),
    .addr_y   (y_sel),
    .addr_w   (eff_w),
    .dx       (dx_sel),
    .dy       (dy_sel),
    .wgt      (wgt_r),
    .pix_byte (pix_r[{ch_r, 3'b000} +: 8]),
    .prod_r   (prod)
  );

  // Pixel memory: address is row times width plus column.
  assign mem_addr = prod[AW-1:0] + AW'(x_sel);

  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      mem[mem_addr] <= wr_word_r;
    end
    if (ctl.mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Channel accumulators; each product is added in the cycle after it was started.
  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= '0;
      end
    end else if (acc_en_r) begin
      acc_r[acc_ch_r] <= acc_r[acc_ch_r] + $signed(prod[ACC_W-1:0]);
    end
  end

  // Round up, drop the weight fraction and saturate each channel.
  always_comb begin
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shr;
    smp_word = '0;
    for (int i = 0; i < 4; i++) begin
      rnd = acc_r[i] + $signed(ROUND_ADD);
      shr = rnd >>> (2 * FRAC_BITS);
      if (shr[ACC_W-1]) begin
        smp_word[i*8 +: 8] = 8'd0;
      end else if (shr > $signed(ACC_W'(255))) begin
        smp_word[i*8 +: 8] = 8'd255;
      end else begin
        smp_word[i*8 +: 8] = shr[7:0];
      end
    end
  end

  // Result word by operation.
  always_comb begin
    res_word = '0;
    if (op_r == OP_SAMPLE) begin
      res_word = smp_word;
    end else if ((op_r == OP_READ) && !oor_r) begin
      res_word = rdata_r;
    end
    if (!alpha_en_r) begin
      res_word[31:24] = 8'd0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.out_ld) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      out_tdata_r <= res_word;
      out_tuser_r <= oor_r && (op_r != OP_SAMPLE);
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

`ifndef SYNTH
  // A request that gives a result keeps the input closed in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != OP_NONE)) |=> !in_tready)
    else $error("input accepted while a request is in progress");

  // Accumulation happens only for a sample.
  a_acc_only_sample: assert property (@(posedge clk) disable iff (!rst_n)
    acc_en_r |-> (op_r == OP_SAMPLE))
    else $error("channel accumulate outside a sample");

  // The memory is written only by an in-range write request.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mem_we |-> (!oor_r && (op_r == OP_WRITE)))
    else $error("pixel memory written for an out-of-range or non-write request");

  // A new result appears only from the output state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output state");

  // All four corners have been visited when the last product drains.
  a_corners_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> ((k_r == 2'd0) && acc_en_r))
    else $error("sample finished without four corners");
`endif

endmodule

// ----- rtl/bras_mul.sv -----
module bras_mul
  import bras_pkg::*;
#(
  parameter int Y_W    = 8,
  parameter int W_W    = 9,
  parameter int DIFF_W = 18
) (
  input  logic                         clk,
  input  logic                         en,
  input  mul_sel_t                     sel,
  input  logic [Y_W-1:0]               addr_y,
  input  logic [W_W-1:0]               addr_w,
  input  logic signed [DIFF_W-1:0]     dx,
  input  logic signed [DIFF_W-1:0]     dy,
  input  logic signed [2*DIFF_W-1:0]   wgt,
  input  logic [7:0]                   pix_byte,
  output logic signed [3*DIFF_W-1:0]   prod_r
);

  localparam int MA_W = 2 * DIFF_W;
  localparam int MB_W = DIFF_W;

  logic signed [MA_W-1:0] op_a;
  logic signed [MB_W-1:0] op_b;

  // Operand selection: row address, corner weight or channel product.
  always_comb begin
    unique case (sel)
      MS_ADDR: begin
        op_a = $signed({{(MA_W-Y_W){1'b0}}, addr_y});
        op_b = $signed({{(MB_W-W_W){1'b0}}, addr_w});
      end
      MS_WGT: begin
        op_a = $signed({{(MA_W-DIFF_W){dx[DIFF_W-1]}}, dx});
        op_b = dy;
      end
      MS_MAC: begin
        op_a = wgt;
        op_b = $signed({{(MB_W-8){1'b0}}, pix_byte});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Registered product.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import bras_pkg::*;

  localparam int FRAC            = FRAC_BITS_DEF;
  localparam int STORE_DEPTH     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_CYCLES     = 3000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int PRESSURE_ITEMS  = 40;

  // One result transaction, laid out as {out_tuser, out_tdata}.
  typedef struct packed {
    logic       out_of_range;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_answer_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [1:0]            in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Mirror of the image store and the registers.
  logic [31:0]   pixel_mem [STORE_DEPTH];
  bit            pixel_written [STORE_DEPTH];
  logic [8:0]    width_reg  = 9'd256;
  logic [8:0]    height_reg = 9'd256;
  logic          alpha_reg  = 1'b0;
  pixel_answer_t answers_due [$];

  int   mismatch_count = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_start     = 1'b0;
  int   hold_left      = 0;

  bilinear_rgba_sampler_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // A size register of zero acts as one, anything above the maximum as the maximum.
  function automatic int eff_size(input logic [8:0] value, input int maxv);
    if (value == 0) return 1;
    return (value > maxv) ? maxv : int'(value);
  endfunction

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint pixel_floor(input logic signed [16:0] c);
    longint s;
    s = c;
    return s >>> FRAC;
  endfunction

  function automatic int store_index(input longint x, input longint y, input int w);
    return int'(y * w + x);
  endfunction

  function automatic logic signed [16:0] to_fixed(input int px, input int frac);
    int c;
    c = px * (1 << FRAC) + frac;
    return c[16:0];
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", what);
  endfunction

  // Expected answer of one request; writes also update the mirrored store.
  task automatic compute_pixel_answer(input logic [1:0] op, input logic signed [16:0] cx,
                                      input logic signed [16:0] cy, input logic [31:0] rgba,
                                      output bit has_answer, output pixel_answer_t ans);
    int         w, h, idx, ch;
    longint     px, py, sx, sy, x0, y0, x1, y1, one;
    longint     dxa, dxb, dya, dyb, wa, wb, wc, wd, ca, cb, cc, cd, acc, v;
    logic [31:0] word, pa, pb, pc, pd;
    w = eff_size(width_reg, MAX_WIDTH_DEF);
    h = eff_size(height_reg, MAX_HEIGHT_DEF);
    ans = '0;
    has_answer = (op != OP_NONE);
    px = pixel_floor(cx);
    py = pixel_floor(cy);
    sx = cx;
    sy = cy;
    one = longint'(1) <<< FRAC;
    if (op == OP_WRITE || op == OP_READ) begin
      if (px < 0 || py < 0 || px >= w || py >= h) begin
        ans.out_of_range = 1'b1;
      end else begin
        idx = store_index(px, py, w);
        if (op == OP_WRITE) begin
          word = rgba;
          if (!alpha_reg) word[31:24] = 8'h00;
          pixel_mem[idx] = word;
          pixel_written[idx] = 1'b1;
        end else begin
          word = pixel_mem[idx];
          ans.red   = word[7:0];
          ans.green = word[15:8];
          ans.blue  = word[23:16];
          ans.alpha = alpha_reg ? word[31:24] : 8'h00;
        end
      end
    end else if (op == OP_SAMPLE) begin
      // Corners are clamped; the weights use the unclamped coordinate.
      x1 = clamp_to(px + 1, 0, w - 1);
      y1 = clamp_to(py + 1, 0, h - 1);
      x0 = clamp_to(px, 0, w - 1);
      y0 = clamp_to(py, 0, h - 1);
      dxa = x1 * one - sx;
      dxb = sx - x0 * one;
      dya = y1 * one - sy;
      dyb = sy - y0 * one;
      wa = dxa * dya;
      wb = dxa * dyb;
      wc = dxb * dya;
      wd = dxb * dyb;
      pa = pixel_mem[store_index(x0, y0, w)];
      pb = pixel_mem[store_index(x0, y1, w)];
      pc = pixel_mem[store_index(x1, y0, w)];
      pd = pixel_mem[store_index(x1, y1, w)];
      for (ch = 0; ch < 4; ch++) begin
        if (ch < 3 || alpha_reg) begin
          ca = pa[8*ch +: 8];
          cb = pb[8*ch +: 8];
          cc = pc[8*ch +: 8];
          cd = pd[8*ch +: 8];
          acc = wa * ca + wb * cb + wc * cc + wd * cd;
          // Round toward plus infinity, then saturate to a byte.
          v = clamp_to((acc + one * one - 1) >>> (2 * FRAC), 0, 255);
          ans[8*ch +: 8] = v[7:0];
        end
      end
    end
  endtask

  // Store index of a pixel the request would fetch that was never written, else -1.
  function automatic int missing_pixel(input logic [1:0] op, input logic signed [16:0] cx,
                                       input logic signed [16:0] cy);
    int     w, h, idx, i, j;
    longint px, py;
    longint xs [2];
    longint ys [2];
    w = eff_size(width_reg, MAX_WIDTH_DEF);
    h = eff_size(height_reg, MAX_HEIGHT_DEF);
    px = pixel_floor(cx);
    py = pixel_floor(cy);
    if (op == OP_READ) begin
      if (px < 0 || py < 0 || px >= w || py >= h) return -1;
      idx = store_index(px, py, w);
      return pixel_written[idx] ? -1 : idx;
    end
    if (op == OP_SAMPLE) begin
      xs[0] = clamp_to(px, 0, w - 1);
      xs[1] = clamp_to(px + 1, 0, w - 1);
      ys[0] = clamp_to(py, 0, h - 1);
      ys[1] = clamp_to(py + 1, 0, h - 1);
      for (i = 0; i < 2; i++) begin
        for (j = 0; j < 2; j++) begin
          idx = store_index(xs[i], ys[j], w);
          if (!pixel_written[idx]) return idx;
        end
      end
    end
    return -1;
  endfunction

  // Mostly inside the active window, sometimes on or past the edges, sometimes anywhere.
  function automatic logic signed [16:0] pick_coord(input int origin, input int span,
                                                    input int size);
    int c, frac;
    frac = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: begin
        c = $urandom_range(0, 1) ? 0 : size * 256 - 1;
      end
      1: begin
        c = $urandom_range(0, 1) ? -int'($urandom_range(1, 256)) : size * 256 + frac;
      end
      2: begin
        c = $urandom;
      end
      default: begin
        c = (origin + int'($urandom_range(0, span - 1))) * 256 + frac;
      end
    endcase
    return c[16:0];
  endfunction

  // Offer one request transaction and record its expected answer once accepted.
  task automatic send_request(input logic [1:0] op, input logic signed [16:0] cx,
                              input logic signed [16:0] cy, input logic [31:0] rgba);
    bit            has_answer;
    pixel_answer_t ans;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, rgba, cy, cx};
    do @(posedge clk); while (!in_tready);
    compute_pixel_answer(op, cx, cy, rgba, has_answer, ans);
    if (has_answer) answers_due.push_back(ans);
  endtask

  task automatic send_random_request(input int win_x, input int win_y, input int win_w,
                                     input int win_h, output bit answered);
    int                 pick, hole, w, h, tmp;
    logic [1:0]         op;
    logic signed [16:0] cx, cy;
    w = eff_size(width_reg, MAX_WIDTH_DEF);
    h = eff_size(height_reg, MAX_HEIGHT_DEF);
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_WRITE;
    else if (pick < 55) op = OP_READ;
    else if (pick < 95) op = OP_SAMPLE;
    else op = OP_NONE;
    cx = pick_coord(win_x, win_w, w);
    cy = pick_coord(win_y, win_h, h);
    hole = missing_pixel(op, cx, cy);
    if (hole >= 0) begin
      // Fill the unwritten neighbor first so no fetch ever sees an unwritten entry.
      op = OP_WRITE;
      tmp = (hole % w) * 256 + int'($urandom_range(0, 255));
      cx = tmp[16:0];
      tmp = (hole / w) * 256 + int'($urandom_range(0, 255));
      cy = tmp[16:0];
    end
    answered = (op != OP_NONE);
    send_request(op, cx, cy, $urandom);
  endtask

  // Let every expected answer arrive, then give the block time to go idle.
  task automatic wait_for_answers;
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, read it back, and update the mirror.
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    logic [31:0] readback, wanted;
    wanted = (index == REG_ALPHA) ? {31'b0, value[0]} : {23'b0, value[8:0]};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (readback !== wanted) begin
      note_mismatch($sformatf("register %0d readback: expected %h, got %h",
                              index, wanted, readback));
    end
    case (index)
      REG_WIDTH:  width_reg  = value[8:0];
      REG_HEIGHT: height_reg = value[8:0];
      REG_ALPHA:  alpha_reg  = value[0];
      default: ;
    endcase
  endtask

  // Upper bits of each write carry noise that the registers must drop.
  task automatic set_image(input int w, input int h, input bit alpha);
    logic [31:0] v;
    v = $urandom;
    v[8:0] = w[8:0];
    write_register(REG_WIDTH, v);
    v = $urandom;
    v[8:0] = h[8:0];
    write_register(REG_HEIGHT, v);
    v = $urandom;
    v[0] = alpha;
    write_register(REG_ALPHA, v);
  endtask

  // Small image with alpha: fill it, then hit edges, clamps and the ignored code.
  task automatic test_directed;
    logic [31:0] word;
    int          x, y;
    set_image(4, 3, 1'b1);
    for (y = 0; y < 3; y++) begin
      for (x = 0; x < 4; x++) begin
        word = $urandom;
        if (x == 0 && y == 0) word = '1;
        if (x == 3 && y == 2) word = '0;
        send_request(OP_WRITE, to_fixed(x, $urandom_range(0, 255)),
                     to_fixed(y, (x == 1) ? 255 : 0), word);
      end
    end
    // Writes just outside the left and bottom edges.
    send_request(OP_WRITE, to_fixed(-1, 255), to_fixed(1, 0), $urandom);
    send_request(OP_WRITE, to_fixed(2, 0), to_fixed(3, 0), $urandom);
    send_request(OP_READ, to_fixed(3, 128), to_fixed(2, 255), $urandom);
    // Reads at the largest and the most negative coordinate.
    send_request(OP_READ, to_fixed(255, 255), to_fixed(0, 0), $urandom);
    send_request(OP_READ, to_fixed(-256, 0), to_fixed(1, 0), $urandom);
    send_request(OP_SAMPLE, to_fixed(1, 128), to_fixed(1, 128), $urandom);
    send_request(OP_SAMPLE, to_fixed(-256, 0), to_fixed(-256, 0), $urandom);
    send_request(OP_SAMPLE, to_fixed(255, 255), to_fixed(255, 255), $urandom);
    send_request(OP_SAMPLE, to_fixed(2, 0), to_fixed(1, 0), $urandom);
    send_request(OP_NONE, to_fixed(1, 0), to_fixed(1, 0), $urandom);
    // The right neighbor is clamped back onto the last column.
    send_request(OP_SAMPLE, to_fixed(3, 128), to_fixed(0, 64), $urandom);
    send_request(OP_READ, to_fixed(0, 0), to_fixed(0, 0), $urandom);
    wait_for_answers;
  endtask

  // Without alpha the fourth byte is stored as zero and returned as zero.
  task automatic test_alpha_disabled;
    set_image(4, 3, 1'b0);
    send_request(OP_WRITE, to_fixed(1, 17), to_fixed(1, 200), {8'hAB, 24'($urandom)});
    send_request(OP_READ, to_fixed(1, 0), to_fixed(1, 0), $urandom);
    send_request(OP_READ, to_fixed(0, 0), to_fixed(0, 0), $urandom);
    send_request(OP_SAMPLE, to_fixed(0, 128), to_fixed(0, 128), $urandom);
    wait_for_answers;
  endtask

  // Random traffic over several image sizes, including size registers of zero and above the
  // maximum, with the four idling patterns in turn.
  task automatic test_random_traffic;
    int phase, w, h, win_w, win_h, win_x, win_y, count;
    bit alpha, answered;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       begin w = 256; h = 256; alpha = 1'b1; end
        1:       begin w = 1;   h = 1;   alpha = 1'b0; end
        2:       begin w = 0;   h = 5;   alpha = 1'b1; end
        3:       begin w = 511; h = 2;   alpha = 1'b1; end
        4:       begin w = 7;   h = 9;   alpha = 1'b0; end
        5:       begin w = 256; h = 1;   alpha = 1'b1; end
        6:       begin w = 3;   h = 511; alpha = 1'b0; end
        default: begin w = 16;  h = 16;  alpha = 1'b1; end
      endcase
      set_image(w, h, alpha);
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      // Large images are exercised through a small window, often against an edge.
      w = eff_size(width_reg, MAX_WIDTH_DEF);
      h = eff_size(height_reg, MAX_HEIGHT_DEF);
      win_w = (w < 8) ? w : 8;
      win_h = (h < 8) ? h : 8;
      case ($urandom_range(0, 3))
        0:       begin win_x = 0;             win_y = h - win_h; end
        1:       begin win_x = w - win_w;     win_y = 0;         end
        default: begin
          win_x = $urandom_range(0, w - win_w);
          win_y = $urandom_range(0, h - win_h);
        end
      endcase
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        send_random_request(win_x, win_y, win_w, win_h, answered);
        if (answered) count++;
      end
      wait_for_answers;
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure;
    int w, h, n;
    bit answered;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    w = eff_size(width_reg, MAX_WIDTH_DEF);
    h = eff_size(height_reg, MAX_HEIGHT_DEF);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (n = 0; n < PRESSURE_ITEMS; n++) begin
      send_random_request(0, 0, (w < 8) ? w : 8, (h < 8) ? h : 8, answered);
    end
    wait_for_answers;
  endtask

  // Receiver side: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_start) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest expected answer.
  always @(posedge clk) begin : result_check
    pixel_answer_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (answers_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result: r=%0d g=%0d b=%0d a=%0d oor=%0d",
                                got.red, got.green, got.blue, got.alpha, got.out_of_range));
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          note_mismatch($sformatf(
            "result mismatch: expected r=%0d g=%0d b=%0d a=%0d oor=%0d, got r=%0d g=%0d b=%0d a=%0d oor=%0d",
            want.red, want.green, want.blue, want.alpha, want.out_of_range,
            got.red, got.green, got.blue, got.alpha, got.out_of_range));
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed;
    test_alpha_disabled;
    test_random_traffic;
    test_output_backpressure;
    wait_for_answers;
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bras_pkg.sv
rtl/bras_mul.sv
rtl/bilinear_rgba_sampler_top.sv
tb/tb_top.sv
